// ===== hw/rtl/life_rle_pkg.sv =====
// ----------------------------------------------------------------------------
// life_rle_pkg
// Shared widths, character codes and status codes for the run decoder.
// ----------------------------------------------------------------------------
package life_rle_pkg;

    // largest grid the decoder addresses
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    // port and state widths
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CHAR_W    = 8;
    localparam int POS_W     = 17;
    localparam int START_W   = 16;
    localparam int LEN_W     = 17;
    localparam int COUNT_W   = 17;
    localparam int STATUS_W  = 2;

    // effective grid dimensions and column remainders
    localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // run count saturates here
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(65536);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     GRID_RESET      = CFG_W'(8);

    // character codes
    localparam logic [CHAR_W-1:0] CH_DEAD = 8'h62;  // b
    localparam logic [CHAR_W-1:0] CH_LIVE = 8'h6F;  // o
    localparam logic [CHAR_W-1:0] CH_EOL  = 8'h24;  // $
    localparam logic [CHAR_W-1:0] CH_END  = 8'h21;  // !
    localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLAMPED  = 2'd2;

    // status of the serial remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } rem_status_t;

endpackage

// ===== hw/rtl/life_rle_remainder.sv =====
// ----------------------------------------------------------------------------
// life_rle_remainder
// Serial restoring remainder unit: reduces the cell position and the run
// count modulo a new grid width, one dividend bit per cycle for both.
// ----------------------------------------------------------------------------
module life_rle_remainder
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [life_rle_pkg::POS_W-1:0]   dividend_a,
    input  logic [life_rle_pkg::POS_W-1:0]   dividend_b,
    input  logic [life_rle_pkg::DIM_W-1:0]   divisor,
    output life_rle_pkg::rem_status_t        stat,
    output logic [life_rle_pkg::COL_W-1:0]   rem_a,
    output logic [life_rle_pkg::COL_W-1:0]   rem_b
);
    import life_rle_pkg::*;

    localparam int STEP_W  = $clog2(POS_W + 1);
    localparam int TRIAL_W = COL_W + 1;

    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [POS_W-1:0]   sh_a_reg;
    logic [POS_W-1:0]   sh_b_reg;
    logic [COL_W-1:0]   r_a_reg;
    logic [COL_W-1:0]   r_b_reg;

    logic [TRIAL_W-1:0] trial_a;
    logic [TRIAL_W-1:0] trial_b;
    logic [TRIAL_W-1:0] div_ext;
    logic [COL_W-1:0]   r_a_next;
    logic [COL_W-1:0]   r_b_next;

    always_comb
    begin
        div_ext  = TRIAL_W'(divisor);
        trial_a  = {r_a_reg, sh_a_reg[POS_W-1]};
        trial_b  = {r_b_reg, sh_b_reg[POS_W-1]};
        r_a_next = (trial_a >= div_ext) ? COL_W'(trial_a - div_ext) : COL_W'(trial_a);
        r_b_next = (trial_b >= div_ext) ? COL_W'(trial_b - div_ext) : COL_W'(trial_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(POS_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_a_reg <= dividend_a;
            sh_b_reg <= dividend_b;
            r_a_reg  <= '0;
            r_b_reg  <= '0;
        end
        else if (busy_reg)
        begin
            sh_a_reg <= {sh_a_reg[POS_W-2:0], 1'b0};
            sh_b_reg <= {sh_b_reg[POS_W-2:0], 1'b0};
            r_a_reg  <= r_a_next;
            r_b_reg  <= r_b_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem_a     = r_a_reg;
    assign rem_b     = r_b_reg;

endmodule

// ===== hw/rtl/life_rle_run_decoder.sv =====
// ----------------------------------------------------------------------------
// life_rle_run_decoder
// Decodes the body of a run-length coded cell pattern into runs of cells.
// ----------------------------------------------------------------------------
// Usage:
//   character / char_valid / char_stall carry one byte of the pattern body
//   per item. Digits build a count; b and o give a run of dead or live cells,
//   $ ends rows, ! fills the rest of the grid and ends the pattern.
//   Runs leave on run_valid / run_stall as cell_value, start_index,
//   run_length, status and pattern_end; an item gives zero or one run.
//   grid_width (index 0) and grid_height (index 1) are written through
//   cfg_write_en / cfg_index / cfg_data while the block is idle.
// Timing:
//   one item per cycle sustained unless run_stall or the remainder unit holds;
//   a decoded item leaves the input register as its run enters run_valid.
//   A grid_width write reduces the position and count modulo the new width
//   in a serial remainder unit; char_stall is high until the results return.
// Reset:
//   the grid returns to 8 by 8 and all decoding state clears at once.
// Stalls:
//   while run_stall holds the output register, one more item can wait in
//   the input register; after that char_stall rises.
// ----------------------------------------------------------------------------
module life_rle_run_decoder
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 char_valid,
    output logic                                 char_stall,
    input  logic [life_rle_pkg::CHAR_W-1:0]      character,
    input  logic                                 cfg_write_en,
    input  logic [life_rle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [life_rle_pkg::CFG_W-1:0]       cfg_data,
    output logic                                 run_valid,
    input  logic                                 run_stall,
    output logic                                 cell_value,
    output logic [life_rle_pkg::START_W-1:0]     start_index,
    output logic [life_rle_pkg::LEN_W-1:0]       run_length,
    output logic [life_rle_pkg::STATUS_W-1:0]    status,
    output logic                                 pattern_end
);
    import life_rle_pkg::*;

    localparam int DIGIT_W = 4;
    localparam int WANT_W  = COUNT_W + DIM_W;
    localparam int CW1     = COL_W + 1;
    localparam int MODV_W  = COL_W + 4;
    localparam int PROD_W  = COUNT_W + 4;

    // configuration
    logic [CFG_W-1:0]    grid_width_reg;
    logic [CFG_W-1:0]    grid_height_reg;
    logic [DIM_W-1:0]    w_eff;
    logic [HDIM_W-1:0]   h_eff;
    logic [POS_W-1:0]    total_reg;

    // decoding state
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COL_W-1:0]    cr_reg, cr_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic                rf_reg, rf_next;
    logic                finished_reg, finished_next;
    logic                error_reg, error_next;

    // input register
    logic                a_valid_reg;
    logic [CHAR_W-1:0]   a_char_reg;

    // output register
    logic                run_valid_reg;
    logic                cell_value_reg;
    logic [START_W-1:0]  start_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                end_reg;

    // remainder unit
    rem_status_t         rem_stat;
    logic                rem_start;
    logic [COL_W-1:0]    rem_col;
    logic [COL_W-1:0]    rem_cr;

    // handshake
    logic                hold;
    logic                out_free;
    logic                a_go;

    // datapath
    logic                is_break;
    logic                is_digit;
    logic                is_tag;
    logic [DIGIT_W-1:0]  digit;
    logic [PROD_W-1:0]   prod10;
    logic                sat;
    logic [MODV_W-1:0]   modv;
    logic [MODV_W-1:0]   w_modv;
    logic [COL_W-1:0]    cr_digit;
    logic [COUNT_W-1:0]  n_eff;
    logic [COL_W-1:0]    crn;
    logic [POS_W-1:0]    left;
    logic                bo_clamp;
    logic                bo_reach;
    logic [POS_W-1:0]    bo_len;
    logic [CW1-1:0]      sum_col;
    logic [CW1-1:0]      w_cw1;
    logic [COL_W-1:0]    wrap_col;
    logic [COL_W-1:0]    bo_col;
    logic [COUNT_W-1:0]  nm1;
    logic [WANT_W-1:0]   rows_cells;
    logic [DIM_W-1:0]    tail;
    logic [WANT_W-1:0]   eol_want;
    logic [WANT_W-1:0]   left_ext;
    logic                eol_clamp;
    logic                eol_reach;
    logic                eol_none;
    logic [POS_W-1:0]    eol_len;
    logic [COL_W-1:0]    eol_col;

    logic                produce;
    logic                r_value;
    logic [START_W-1:0]  r_start;
    logic [LEN_W-1:0]    r_len;
    logic [STATUS_W-1:0] r_status;
    logic                r_end;

    // ---------------- configuration ----------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_RESET;
            grid_height_reg <= GRID_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (int'(grid_width_reg) > MAX_WIDTH)
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = DIM_W'(grid_width_reg);

        if (grid_height_reg == '0)
            h_eff = HDIM_W'(1);
        else if (int'(grid_height_reg) > MAX_HEIGHT)
            h_eff = HDIM_W'(MAX_HEIGHT);
        else
            h_eff = HDIM_W'(grid_height_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= POS_W'(GRID_RESET) * POS_W'(GRID_RESET);
        else
            total_reg <= POS_W'(w_eff) * POS_W'(h_eff);
    end

    // a new width invalidates the column and the count remainder
    assign rem_start = cfg_write_en && (cfg_index == REG_GRID_WIDTH);

    life_rle_remainder u_rem
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (rem_start),
        .dividend_a (pos_reg),
        .dividend_b (count_reg),
        .divisor    (w_eff),
        .stat       (rem_stat),
        .rem_a      (rem_col),
        .rem_b      (rem_cr)
    );

    // ---------------- handshake ----------------

    assign hold       = rem_stat.busy || rem_stat.done;
    assign out_free   = !run_valid_reg || !run_stall;
    assign a_go       = a_valid_reg && !hold && out_free;
    assign char_stall = hold || (a_valid_reg && !out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (char_valid && !char_stall)
            a_valid_reg <= 1'b1;
        else if (a_go)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
            a_char_reg <= character;
    end

    // ---------------- run arithmetic ----------------

    always_comb
    begin
        is_break = (a_char_reg == CH_LF) || (a_char_reg == CH_CR);
        is_digit = (a_char_reg >= CH_ZERO) && (a_char_reg <= CH_NINE);
        is_tag   = (a_char_reg == CH_DEAD) || (a_char_reg == CH_LIVE);
        digit    = DIGIT_W'(a_char_reg - CH_ZERO);

        // count * 10 + digit, saturating
        prod10 = {count_reg, 3'b000} + PROD_W'({count_reg, 1'b0}) + PROD_W'(digit);
        sat    = prod10 > PROD_W'(COUNT_LIMIT);

        // remainder of the count by the width, kept one digit at a time
        modv     = MODV_W'(cr_reg) * MODV_W'(10) + MODV_W'(digit);
        w_modv   = MODV_W'(w_eff);
        cr_digit = COL_W'(modv);
        for (int k = 1; k <= 9; k++)
        begin
            if (modv >= MODV_W'(k) * w_modv)
                cr_digit = COL_W'(modv - MODV_W'(k) * w_modv);
        end

        n_eff = (count_reg == '0) ? COUNT_W'(1) : count_reg;
        if (count_reg != '0)
            crn = cr_reg;
        else if (w_eff == DIM_W'(1))
            crn = '0;
        else
            crn = COL_W'(1);

        left = (total_reg > pos_reg) ? (total_reg - pos_reg) : '0;

        // b and o
        bo_clamp = n_eff > left;
        bo_reach = n_eff >= left;
        bo_len   = bo_clamp ? left : n_eff;
        sum_col  = CW1'(col_reg) + CW1'(crn);
        w_cw1    = CW1'(w_eff);
        wrap_col = (sum_col >= w_cw1) ? COL_W'(sum_col - w_cw1) : COL_W'(sum_col);
        if (bo_len == '0)
            bo_col = col_reg;
        else if (bo_reach)
            bo_col = '0;
        else
            bo_col = wrap_col;

        // $: rest of this row unless cells just filled it, then count-1 rows
        nm1        = n_eff - COUNT_W'(1);
        rows_cells = WANT_W'(nm1) * WANT_W'(w_eff);
        tail       = rf_reg ? '0 : DIM_W'(w_eff - DIM_W'(col_reg));
        eol_want   = rows_cells + WANT_W'(tail);
        left_ext   = WANT_W'(left);
        eol_clamp  = eol_want > left_ext;
        eol_reach  = eol_want >= left_ext;
        eol_none   = eol_want == '0;
        eol_len    = eol_clamp ? left : POS_W'(eol_want);
        if (eol_len == '0)
            eol_col = col_reg;
        else if (eol_reach || !rf_reg)
            eol_col = '0;
        else
            eol_col = col_reg;
    end

    // ---------------- item decode ----------------

    always_comb
    begin
        produce       = 1'b0;
        r_value       = 1'b0;
        r_start       = '0;
        r_len         = '0;
        r_status      = ST_OK;
        r_end         = 1'b0;
        count_next    = count_reg;
        cr_next       = cr_reg;
        pos_next      = pos_reg;
        col_next      = col_reg;
        rf_next       = rf_reg;
        finished_next = finished_reg;
        error_next    = error_reg;

        if (!finished_reg && !is_break)
        begin
            priority if (error_reg)
            begin
                produce  = 1'b1;
                r_status = ST_BAD_CHAR;
            end
            else if (is_digit)
            begin
                count_next = sat ? COUNT_LIMIT : COUNT_W'(prod10);
                // a saturated count always reaches the grid end, so its remainder is unused
                cr_next    = sat ? '0 : cr_digit;
            end
            else if (is_tag)
            begin
                produce    = 1'b1;
                r_value    = (a_char_reg == CH_LIVE);
                r_len      = LEN_W'(bo_len);
                r_start    = (bo_len == '0) ? '0 : START_W'(pos_reg);
                r_status   = bo_clamp ? ST_CLAMPED : ST_OK;
                count_next = '0;
                cr_next    = '0;
                pos_next   = pos_reg + bo_len;
                col_next   = bo_col;
                rf_next    = (bo_len != '0) && (bo_col == '0);
            end
            else if (a_char_reg == CH_EOL)
            begin
                count_next = '0;
                cr_next    = '0;
                rf_next    = 1'b0;
                if (!eol_none)
                begin
                    produce  = 1'b1;
                    r_len    = LEN_W'(eol_len);
                    r_start  = (eol_len == '0) ? '0 : START_W'(pos_reg);
                    r_status = eol_clamp ? ST_CLAMPED : ST_OK;
                    pos_next = pos_reg + eol_len;
                    col_next = eol_col;
                end
            end
            else if (a_char_reg == CH_END)
            begin
                produce       = 1'b1;
                r_len         = LEN_W'(left);
                r_start       = (left == '0) ? '0 : START_W'(pos_reg);
                r_end         = 1'b1;
                count_next    = '0;
                cr_next       = '0;
                rf_next       = 1'b0;
                pos_next      = pos_reg + left;
                col_next      = (left == '0) ? col_reg : '0;
                finished_next = 1'b1;
            end
            else
            begin
                produce    = 1'b1;
                r_status   = ST_BAD_CHAR;
                error_next = 1'b1;
                count_next = '0;
                cr_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            cr_reg       <= '0;
            pos_reg      <= '0;
            col_reg      <= '0;
            rf_reg       <= 1'b0;
            finished_reg <= 1'b0;
            error_reg    <= 1'b0;
        end
        else if (rem_stat.done)
        begin
            col_reg <= rem_col;
            cr_reg  <= rem_cr;
        end
        else if (a_go)
        begin
            count_reg    <= count_next;
            cr_reg       <= cr_next;
            pos_reg      <= pos_next;
            col_reg      <= col_next;
            rf_reg       <= rf_next;
            finished_reg <= finished_next;
            error_reg    <= error_next;
        end
    end

    // ---------------- output register ----------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_valid_reg <= 1'b0;
        else if (a_go && produce)
            run_valid_reg <= 1'b1;
        else if (!run_stall)
            run_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_go && produce)
        begin
            cell_value_reg <= r_value;
            start_reg      <= r_start;
            len_reg        <= r_len;
            status_reg     <= r_status;
            end_reg        <= r_end;
        end
    end

    assign run_valid   = run_valid_reg;
    assign cell_value  = cell_value_reg;
    assign start_index = start_reg;
    assign run_length  = len_reg;
    assign status      = status_reg;
    assign pattern_end = end_reg;

endmodule

// ===== hw/rtl/life_rle_checker.sv =====
// ----------------------------------------------------------------------------
// life_rle_checker
// Port-level checks on the run output of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module life_rle_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 run_valid,
    input logic                                 run_stall,
    input logic                                 cell_value,
    input logic [life_rle_pkg::START_W-1:0]     start_index,
    input logic [life_rle_pkg::LEN_W-1:0]       run_length,
    input logic [life_rle_pkg::STATUS_W-1:0]    status,
    input logic                                 pattern_end
);
    import life_rle_pkg::*;

    // a stalled run holds
    a_run_hold: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && run_stall |=> run_valid && $stable(cell_value) &&
        $stable(start_index) && $stable(run_length) && $stable(status) &&
        $stable(pattern_end))
        else $error("run changed while stalled");

    // nothing follows the closing run
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && !run_stall && pattern_end |=> !run_valid)
        else $error("run after pattern end");

    // once an unknown character is seen every later run is an error
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && !run_stall && (status == ST_BAD_CHAR)
        |=> !run_valid || (status == ST_BAD_CHAR))
        else $error("error status not sticky");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && (status == ST_BAD_CHAR) |-> (run_length == '0) &&
        (start_index == '0) && !pattern_end && !cell_value)
        else $error("malformed error run");

    // an ordinary unclamped run always covers cells
    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && (status == ST_OK) && !pattern_end |-> run_length != '0)
        else $error("empty ok run");

endmodule

bind life_rle_run_decoder life_rle_checker u_checker (.*);

// ===== test/tb_life_rle_run_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_life_rle_run_decoder
// Self-checking bench for the run decoder. A short scripted pattern body runs
// on the reset grid, then random pattern bodies run over a series of grid
// sizes, and the body ends with either an end mark or an unknown character.
// Every run is compared field by field with a run typed in the script or one
// from a behavioral decoder that steps on each accepted character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_life_rle_run_decoder;

    import life_rle_pkg::*;

    typedef struct packed {
        logic                live;
        logic [START_W-1:0]  start_idx;
        logic [LEN_W-1:0]    len;
        logic [STATUS_W-1:0] st;
        logic                fin;
    } run_result_t;

    typedef enum logic [1:0] {OUT_NONE, OUT_TYPED, OUT_PREDICTED} row_kind_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        row_kind_t         kind;
        run_result_t       run;
    } script_row_t;

    localparam run_result_t NO_RUN = '0;
    localparam int OPEN_ROWS = 27;
    localparam int HOLD_CYCLES = 64;
    localparam int SETTLE_CYCLES = 24;

    // opening pattern on the 8 by 8 grid after reset
    script_row_t opening_script [OPEN_ROWS] = '{
        '{CH_LIVE, OUT_TYPED, '{1'b1, 16'd0,  17'd1, ST_OK, 1'b0}},
        '{"3",     OUT_NONE,  NO_RUN},
        '{CH_DEAD, OUT_TYPED, '{1'b0, 16'd1,  17'd3, ST_OK, 1'b0}},
        // rest of the row, then a whole row for a row end after a row end
        '{CH_EOL,  OUT_TYPED, '{1'b0, 16'd4,  17'd4, ST_OK, 1'b0}},
        '{CH_EOL,  OUT_TYPED, '{1'b0, 16'd8,  17'd8, ST_OK, 1'b0}},
        '{"8",     OUT_NONE,  NO_RUN},
        '{CH_LIVE, OUT_TYPED, '{1'b1, 16'd16, 17'd8, ST_OK, 1'b0}},
        // row already filled by cells: no extra row
        '{CH_EOL,  OUT_NONE,  NO_RUN},
        '{CH_EOL,  OUT_TYPED, '{1'b0, 16'd24, 17'd8, ST_OK, 1'b0}},
        '{"8",     OUT_NONE,  NO_RUN},
        '{CH_LIVE, OUT_TYPED, '{1'b1, 16'd32, 17'd8, ST_OK, 1'b0}},
        '{"2",     OUT_NONE,  NO_RUN},
        '{CH_EOL,  OUT_PREDICTED, NO_RUN},
        // zero count acts as one
        '{"0",     OUT_NONE,  NO_RUN},
        '{CH_DEAD, OUT_TYPED, '{1'b0, 16'd48, 17'd1, ST_OK, 1'b0}},
        // line breaks inside a count and before its tag
        '{"1",     OUT_NONE,  NO_RUN},
        '{CH_CR,   OUT_NONE,  NO_RUN},
        '{"2",     OUT_NONE,  NO_RUN},
        '{CH_LF,   OUT_NONE,  NO_RUN},
        '{CH_LIVE, OUT_PREDICTED, NO_RUN},
        // saturated count, clamped at the grid end
        '{"9",     OUT_NONE,  NO_RUN},
        '{"9",     OUT_NONE,  NO_RUN},
        '{"9",     OUT_NONE,  NO_RUN},
        '{"9",     OUT_NONE,  NO_RUN},
        '{"9",     OUT_NONE,  NO_RUN},
        '{CH_DEAD, OUT_TYPED, '{1'b0, 16'd61, 17'd3, ST_CLAMPED, 1'b0}},
        '{CH_LIVE, OUT_TYPED, '{1'b1, 16'd0,  17'd0, ST_CLAMPED, 1'b0}}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                char_valid;
    logic                char_stall;
    logic [CHAR_W-1:0]   character;
    logic                cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                run_valid;
    logic                run_stall = 1'b0;
    logic                cell_value;
    logic [START_W-1:0]  start_index;
    logic [LEN_W-1:0]    run_length;
    logic [STATUS_W-1:0] status;
    logic                pattern_end;

    // behavioral decoder state
    logic [CFG_W-1:0] grid_w_cfg = GRID_RESET;
    logic [CFG_W-1:0] grid_h_cfg = GRID_RESET;
    longint           pending_count = 0;
    longint           cell_pos = 0;
    bit               row_closed = 1'b0;
    bit               pattern_done = 1'b0;
    bit               bad_char_seen = 1'b0;

    run_result_t expected_runs[$];
    int          error_count = 0;
    int          chars_sent = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;

    life_rle_run_decoder dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .character    (character),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .run_valid    (run_valid),
        .run_stall    (run_stall),
        .cell_value   (cell_value),
        .start_index  (start_index),
        .run_length   (run_length),
        .status       (status),
        .pattern_end  (pattern_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        if (error_count < 40)
            $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned active_width();
        if (grid_w_cfg == 0) return 1;
        if (grid_w_cfg > MAX_WIDTH) return MAX_WIDTH;
        return grid_w_cfg;
    endfunction

    function automatic int unsigned active_height();
        if (grid_h_cfg == 0) return 1;
        if (grid_h_cfg > MAX_HEIGHT) return MAX_HEIGHT;
        return grid_h_cfg;
    endfunction

    // run from the current cell, clamped to the cells left in the grid
    function automatic run_result_t place_run(input logic live, input longint wanted,
                                              input logic fin);
        longint total;
        longint left;
        longint len;
        run_result_t r;
        total = longint'(active_width()) * longint'(active_height());
        left = (total > cell_pos) ? total - cell_pos : 0;
        len = wanted;
        r.st = ST_OK;
        if (len > left)
        begin
            len = left;
            r.st = ST_CLAMPED;
        end
        r.live = live;
        r.start_idx = (len == 0) ? '0 : START_W'(cell_pos);
        r.len = LEN_W'(len);
        r.fin = fin;
        cell_pos += len;
        return r;
    endfunction

    // steps the decoder on one character; returns 1 when it gives a run
    function automatic bit decode_char(input logic [CHAR_W-1:0] ch, output run_result_t r);
        longint w;
        longint n;
        longint wanted;
        longint grown;
        r = NO_RUN;
        if (pattern_done) return 1'b0;
        if (ch == CH_LF || ch == CH_CR) return 1'b0;
        if (bad_char_seen)
        begin
            r.st = ST_BAD_CHAR;
            return 1'b1;
        end
        w = active_width();
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            grown = pending_count * 10 + longint'(ch - CH_ZERO);
            pending_count = (grown > COUNT_LIMIT) ? COUNT_LIMIT : grown;
            return 1'b0;
        end
        n = (pending_count == 0) ? 1 : pending_count;
        pending_count = 0;
        if (ch == CH_DEAD || ch == CH_LIVE)
        begin
            r = place_run(ch == CH_LIVE, n, 1'b0);
            row_closed = (r.len != 0) && (cell_pos % w == 0);
            return 1'b1;
        end
        if (ch == CH_EOL)
        begin
            wanted = (n - 1) * w;
            if (!row_closed) wanted += w - (cell_pos % w);
            row_closed = 1'b0;
            if (wanted == 0) return 1'b0;
            r = place_run(1'b0, wanted, 1'b0);
            return 1'b1;
        end
        if (ch == CH_END)
        begin
            row_closed = 1'b0;
            r = place_run(1'b0, w * longint'(active_height()), 1'b1);
            // filling to the end is never a clamp
            r.st = ST_OK;
            pattern_done = 1'b1;
            return 1'b1;
        end
        bad_char_seen = 1'b1;
        r.st = ST_BAD_CHAR;
        return 1'b1;
    endfunction

    // queue a run at the tail of the expected list
    task automatic add_expected(input run_result_t r);
        expected_runs = {expected_runs, r};
    endtask

    task automatic offer_char(input logic [CHAR_W-1:0] ch);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        character  <= ch;
        @(posedge clk);
        while (char_stall) @(posedge clk);
        chars_sent++;
    endtask

    task automatic push_char(input logic [CHAR_W-1:0] ch);
        run_result_t r;
        offer_char(ch);
        if (decode_char(ch, r)) add_expected(r);
    endtask

    // bounded wait for every run, then room for the remainder pass
    task automatic drain_runs();
        int guard;
        char_valid <= 1'b0;
        guard = 0;
        while (expected_runs.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_grid(input int unsigned w, input int unsigned h);
        drain_runs();
        // height first: a width write starts the remainder pass
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_GRID_HEIGHT;
        cfg_data     <= CFG_W'(h);
        @(posedge clk);
        cfg_index    <= REG_GRID_WIDTH;
        cfg_data     <= CFG_W'(w);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        grid_h_cfg = CFG_W'(h);
        grid_w_cfg = CFG_W'(w);
    endtask

    task automatic send_count(input int unsigned n);
        logic [CHAR_W-1:0] digits[$];
        do
        begin
            digits.push_front(CH_ZERO + CHAR_W'(n % 10));
            n /= 10;
        end
        while (n != 0);
        if ($urandom_range(0, 7) == 0) digits.push_front(CH_ZERO);
        foreach (digits[i])
        begin
            // a line break may sit before any digit of a count
            if ($urandom_range(0, 19) == 0) push_char($urandom_range(0, 1) ? CH_LF : CH_CR);
            push_char(digits[i]);
        end
    endtask

    // one count and tag with random content, or now and then a stray line break
    task automatic send_token(input bit big_ok);
        int unsigned k;
        int unsigned w;
        int unsigned n;
        logic [CHAR_W-1:0] tag;
        w = active_width();
        k = $urandom_range(0, 99);
        if (k < 4)
        begin
            push_char($urandom_range(0, 1) ? CH_LF : CH_CR);
            return;
        end
        tag = (k < 40) ? CH_DEAD : (k < 76) ? CH_LIVE : CH_EOL;
        k = $urandom_range(0, 99);
        if (big_ok && k < 15) n = $urandom_range(1, 99999);
        else if (tag == CH_EOL) n = $urandom_range(0, 3);
        else if (k < 30) n = 0;
        else if (k < 85) n = $urandom_range(1, w);
        else n = $urandom_range(1, 4 * w);
        if (n != 0 || $urandom_range(0, 3) == 0) send_count(n);
        push_char(tag);
    endtask

    task automatic run_phase(input int unsigned w, input int unsigned h, input int items,
                             input bit pause_mid, input bit hold_mid);
        int first;
        bit mid_done;
        set_grid(w, h);
        first = chars_sent;
        mid_done = 1'b0;
        while (chars_sent - first < items)
        begin
            if (!mid_done && chars_sent - first >= items / 2)
            begin
                mid_done = 1'b1;
                if (pause_mid) drain_runs();
                // receiver holds off while the sender keeps offering
                if (hold_mid) hold_toggle <= ~hold_toggle;
            end
            // big counts only near the phase end, so the grid fills late
            send_token(items - (chars_sent - first) < 12);
        end
    endtask

    // result side: random stall, long hold on request, check against the oldest run
    always @(posedge clk)
    begin : run_sink
        run_result_t want;
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (rst_n && run_valid && !run_stall)
        begin
            if (expected_runs.size() == 0)
                flag_error("run with no item waiting for it");
            else
            begin
                want = expected_runs.pop_front();
                if (cell_value !== want.live)
                    flag_error($sformatf("cell_value %0d, want %0d", cell_value, want.live));
                if (start_index !== want.start_idx)
                    flag_error($sformatf("start_index %0d, want %0d",
                                         start_index, want.start_idx));
                if (run_length !== want.len)
                    flag_error($sformatf("run_length %0d, want %0d", run_length, want.len));
                if (status !== want.st)
                    flag_error($sformatf("status %0d, want %0d", status, want.st));
                if (pattern_end !== want.fin)
                    flag_error($sformatf("pattern_end %0d, want %0d", pattern_end, want.fin));
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            run_stall <= 1'b1;
        end
        else
            run_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    initial
    begin
        run_result_t r;
        bit got;
        logic [CHAR_W-1:0] bad;
        rst_n        = 1'b0;
        char_valid   = 1'b0;
        character    = '0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 61;
        for (int i = 0; i < OPEN_ROWS; i++)
        begin
            offer_char(opening_script[i].ch);
            got = decode_char(opening_script[i].ch, r);
            if (opening_script[i].kind == OUT_TYPED)
                add_expected(opening_script[i].run);
            else if (opening_script[i].kind == OUT_PREDICTED && got)
                add_expected(r);
        end

        // the grid changes size from phase to phase, out-of-range settings included
        run_phase(0, 200, 100, 1'b0, 1'b0);
        run_phase(511, 0, 100, 1'b0, 1'b0);
        send_idle_pct = 61;
        recv_idle_pct = 20;
        run_phase(13, 100, 120, 1'b1, 1'b0);
        run_phase(256, 256, 200, 1'b0, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(1, 511, 30, 1'b0, 1'b0);
        run_phase(200, 300, 60, 1'b0, 1'b1);

        // the body ends either at the end mark or at a sticky unknown character
        if ($urandom_range(0, 1))
        begin
            do
                bad = CHAR_W'($urandom_range(0, 255));
            while (bad inside {[CH_ZERO:CH_NINE], CH_DEAD, CH_LIVE, CH_EOL, CH_END,
                               CH_LF, CH_CR});
            push_char(bad);
        end
        else
            push_char(CH_END);
        repeat (40) push_char(CHAR_W'($urandom_range(0, 255)));

        drain_runs();
        if (expected_runs.size() != 0)
            flag_error($sformatf("%0d runs never arrived", expected_runs.size()));
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
